/* rtl/tlpq_pkg.sv */
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared sizes, request and status codes and ring index helpers for the
// two-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

	localparam int unsigned DEPTH      = 16;
	localparam int unsigned DATA_WIDTH = 32;

	localparam int unsigned IDX_W  = $clog2(DEPTH);
	localparam int unsigned SUM_W  = IDX_W + 1;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned REQ_W  = 2;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned ENT_W  = 5;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] data_t;

	localparam logic [REQ_W-1:0] REQ_ENQ_LO = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ENQ_HI = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEQ    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	function automatic idx_t idx_inc(idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic idx_t idx_dec(idx_t i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	function automatic idx_t idx_add(idx_t a, idx_t b);
		logic [SUM_W-1:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= SUM_W'(DEPTH))
			s = s - SUM_W'(DEPTH);
		return s[IDX_W-1:0];
	endfunction

endpackage

/* rtl/tlpq_if.sv */
// ----------------------------------------------------------------------------
// tlpq request and response channels
// Valid/ready channels carrying queue requests and their results.
// ----------------------------------------------------------------------------
interface tlpq_req_if import tlpq_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [VAL_W-1:0] item_value;

	modport source (output valid, req_type, item_value, input ready);
	modport sink   (input valid, req_type, item_value, output ready);
endinterface

interface tlpq_rsp_if import tlpq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  out_value;
	logic [STAT_W-1:0] status;
	logic [ENT_W-1:0]  entries_held;

	modport source (output valid, out_value, status, entries_held, input ready);
	modport sink   (input valid, out_value, status, entries_held, output ready);
endinterface

/* rtl/tlpq_ram.sv */
// ----------------------------------------------------------------------------
// tlpq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tlpq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* rtl/two_level_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// two_level_priority_queue_unit
// Two-level priority queue over one shared ring store. High items sit at the
// front, low items behind them; an enqueue-high slides the high items one
// slot toward the front through the store's single write port.
// Enqueue-low, rejected and unused requests give their registered result in the
// cycle after acceptance; a dequeue passes through S_DEQ (one store read).
// Enqueue-high with H high items held steps through S_SHIFT, one store write
// per moved item, then S_FINAL; with H = 0 it answers like an enqueue-low.
// A new request is taken once the previous result is delivered or leaves.
// Reset clears counters and front index; store contents stay undefined.
// ----------------------------------------------------------------------------
module two_level_priority_queue_unit import tlpq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tlpq_req_if.sink   req,
	tlpq_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ,
		S_SHIFT,
		S_FINAL
	} state_t;

	state_t            state_q;
	idx_t              front_q;
	cnt_t              high_q;
	cnt_t              total_q;
	idx_t              wr_ptr_q;
	idx_t              rd_ptr_q;
	cnt_t              left_q;
	data_t             item_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [STAT_W-1:0] status_q;
	logic [ENT_W-1:0]  entries_q;

	logic  accept;
	logic  full;
	logic  empty;
	data_t item_in;
	cnt_t  total_inc;
	cnt_t  total_dec;

	logic  ram_we;
	idx_t  ram_waddr;
	data_t ram_wdata;
	logic  ram_re;
	idx_t  ram_raddr;
	data_t ram_rdata;

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign full      = (total_q == CNT_W'(DEPTH));
	assign empty     = (total_q == '0);
	assign item_in   = DATA_WIDTH'(req.item_value);
	assign total_inc = total_q + 1'b1;
	assign total_dec = total_q - 1'b1;

	assign rsp.valid        = out_valid_q;
	assign rsp.out_value    = out_value_q;
	assign rsp.status       = status_q;
	assign rsp.entries_held = entries_q;

	tlpq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_ENQ_LO && !full) begin
						ram_we    = 1'b1;
						ram_waddr = idx_add(front_q, IDX_W'(total_q));
						ram_wdata = item_in;
					end else if (req.req_type == REQ_ENQ_HI && !full) begin
						if (high_q == '0) begin
							ram_we    = 1'b1;
							ram_waddr = idx_dec(front_q);
							ram_wdata = item_in;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = front_q;
						end
					end else if (req.req_type == REQ_DEQ && !empty) begin
						ram_re    = 1'b1;
						ram_raddr = front_q;
					end
				end
			end
			S_SHIFT: begin
				ram_we = 1'b1;
				if (left_q > CNT_W'(1))
					ram_re = 1'b1;
			end
			S_FINAL: begin
				ram_we    = 1'b1;
				ram_wdata = item_q;
			end
			S_DEQ: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			high_q      <= '0;
			total_q     <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			left_q      <= '0;
			item_q      <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			status_q    <= STAT_DONE;
			entries_q   <= '0;
		end else begin
			if (out_valid_q && rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_value_q <= '0;
						status_q    <= STAT_DONE;
						entries_q   <= ENT_W'(total_q);
						out_valid_q <= 1'b1;
						unique case (req.req_type)
							REQ_ENQ_LO: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									total_q   <= total_inc;
									entries_q <= ENT_W'(total_inc);
								end
							end
							REQ_ENQ_HI: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									front_q   <= idx_dec(front_q);
									high_q    <= high_q + 1'b1;
									total_q   <= total_inc;
									entries_q <= ENT_W'(total_inc);
									if (high_q != '0) begin
										out_valid_q <= 1'b0;
										state_q     <= S_SHIFT;
										wr_ptr_q    <= idx_dec(front_q);
										rd_ptr_q    <= idx_inc(front_q);
										left_q      <= high_q;
										item_q      <= item_in;
									end
								end
							end
							REQ_DEQ: begin
								if (empty) begin
									status_q <= STAT_EMPTY;
								end else begin
									out_valid_q <= 1'b0;
									state_q     <= S_DEQ;
									front_q     <= idx_inc(front_q);
									total_q     <= total_dec;
									entries_q   <= ENT_W'(total_dec);
									if (high_q != '0)
										high_q <= high_q - 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DEQ: begin
					out_value_q <= VAL_W'(ram_rdata);
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SHIFT: begin
					wr_ptr_q <= idx_inc(wr_ptr_q);
					if (left_q > CNT_W'(1)) begin
						rd_ptr_q <= idx_inc(rd_ptr_q);
						left_q   <= left_q - 1'b1;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	a_high_within_total: assert property (@(posedge clk) disable iff (!arst_n)
		high_q <= total_q)
		else $error("high count exceeds total count");

	a_total_within_depth: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(DEPTH))
		else $error("total count exceeds store depth");

	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !out_valid_q)
		else $error("result pending while a request is in progress");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("store read and write hit the same entry");

	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEQ |=> out_valid_q && status_q == STAT_DONE)
		else $error("dequeue read did not produce a result");

endmodule
